FILE: design/slcd_pkg.sv
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared types, constants and the segment table of the segment LCD renderer.
// ----------------------------------------------------------------------------
package slcd_pkg;

   // command codes
   localparam logic [2:0] MODE_VALUE    = 3'd0;
   localparam logic [2:0] MODE_MEMORY   = 3'd1;
   localparam logic [2:0] MODE_ERROR    = 3'd2;
   localparam logic [2:0] MODE_ICON_ON  = 3'd3;
   localparam logic [2:0] MODE_ICON_OFF = 3'd4;
   localparam logic [2:0] MODE_BLANK    = 3'd5;

   // glyph indexes in the segment table
   localparam logic [3:0] DIGIT_BLANK = 4'd11;
   localparam logic [3:0] GLYPH_A     = 4'd12;
   localparam logic [3:0] GLYPH_B     = 4'd13;

   localparam logic signed [15:0] VALUE_MAX  = 16'sd9999;
   localparam logic signed [15:0] MEMORY_MAX = 16'sd99;

   localparam logic [31:0] DP_BIT        = 32'h0008_0000;
   localparam logic [31:0] MEM_W0_KEEP   = 32'hFFFF_F80F;
   localparam logic [31:0] MEM_W1_KEEP   = 32'hFFFF_FF80;

   // reciprocal multipliers for division by 10, 100 and 1000 of values below 10000
   localparam logic [13:0] RECIP_10    = 14'd6554;
   localparam int          SHIFT_10    = 16;
   localparam logic [13:0] RECIP_100   = 14'd5243;
   localparam int          SHIFT_100   = 19;
   localparam logic [13:0] RECIP_1000  = 14'd8389;
   localparam int          SHIFT_1000  = 23;

   localparam int NUM_ICONS = 14;

   typedef logic [3:0][31:0] glass_words_type;

   // stage 1 result: digit indexes to pack plus the memory-mode patch
   typedef struct packed {
      logic [2:0]  mode;
      logic [3:0]  dig_a;
      logic [3:0]  dig_b;
      logic [3:0]  dig_c;
      logic [3:0]  dig_d;
      logic        mem_ok;
      logic [3:0]  mem_units;
      logic [3:0]  mem_tens;
      logic [13:0] icon_mask;
   } digits_type;

   function automatic logic [15:0] seg_code(input logic [3:0] idx);
      logic [15:0] code;
      case (idx)
         4'd0:    code = 16'h050F;
         4'd1:    code = 16'h0006;
         4'd2:    code = 16'h060B;
         4'd3:    code = 16'h020F;
         4'd4:    code = 16'h0306;
         4'd5:    code = 16'h030D;
         4'd6:    code = 16'h070D;
         4'd7:    code = 16'h0007;
         4'd8:    code = 16'h070F;
         4'd9:    code = 16'h030F;
         4'd10:   code = 16'h0008;
         4'd11:   code = 16'h0000;
         4'd12:   code = 16'h0709;
         4'd13:   code = 16'h0707;
         default: code = 16'h050F;  // 14 wraps to 0
      endcase
      return code;
   endfunction

   function automatic logic [1:0] icon_word(input int idx);
      logic [1:0] w;
      case (idx)
         4, 7:           w = 2'd1;
         5, 8:           w = 2'd2;
         9, 10, 11, 12, 13: w = 2'd3;
         default:        w = 2'd0;
      endcase
      return w;
   endfunction

   function automatic logic [31:0] icon_bit(input int idx);
      logic [31:0] b;
      case (idx)
         0:       b = 32'h0000_0008;
         1:       b = 32'h0000_0004;
         2:       b = 32'h0000_0002;
         3:       b = 32'h0000_0001;
         5:       b = 32'h0000_0008;
         7, 9:    b = 32'h0000_0800;
         11:      b = 32'h0004_0000;
         12:      b = 32'h0002_0000;
         13:      b = 32'h0001_0000;
         default: b = 32'h0008_0000;
      endcase
      return b;
   endfunction

   // glass layout of four digits, a lowest
   function automatic glass_words_type pack_digits(input logic [3:0] a, input logic [3:0] b,
                                                   input logic [3:0] c, input logic [3:0] d);
      logic [15:0]     ca;
      logic [15:0]     cb;
      logic [15:0]     cc;
      logic [15:0]     cd;
      glass_words_type w;
      ca = seg_code(a);
      cb = seg_code(b);
      cc = seg_code(c);
      cd = seg_code(d);
      w[0] = {ca[7:0], 24'h0};
      w[1] = {cb[7:0], ca[15:8], 16'h0};
      w[2] = {cd[7:0], cc, cb[15:8]};
      w[3] = {8'h0, cd[15:8], 16'h0};
      return w;
   endfunction

endpackage

FILE: design/slcd_if.sv
// ----------------------------------------------------------------------------
// slcd channel interfaces
// Command and glass-word channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface slcd_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         mode;
   logic signed [15:0] number_in;
   logic [13:0]        icon_mask;

   modport source (output valid, output mode, output number_in, output icon_mask,
                   input ready);
   modport sink   (input valid, input mode, input number_in, input icon_mask,
                   output ready);
endinterface

interface slcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] glass_word0;
   logic [31:0] glass_word1;
   logic [31:0] glass_word2;
   logic [31:0] glass_word3;

   modport source (output valid, output glass_word0, output glass_word1,
                   output glass_word2, output glass_word3, input ready);
   modport sink   (input valid, input glass_word0, input glass_word1,
                   input glass_word2, input glass_word3, output ready);
endinterface

FILE: design/slcd_digits.sv
// ----------------------------------------------------------------------------
// slcd_digits
// Splits a command's number into decimal digits and picks the glyphs to pack.
// ----------------------------------------------------------------------------
module slcd_digits (
   input  logic [2:0]         mode,
   input  logic signed [15:0] number_in,
   input  logic [13:0]        icon_mask,
   output slcd_pkg::digits_type digits
);
   import slcd_pkg::*;

   logic [13:0] v;
   logic [27:0] prod_10;
   logic [27:0] prod_100;
   logic [27:0] prod_1000;
   logic [9:0]  q1;
   logic [6:0]  q2;
   logic [3:0]  q3;
   logic [3:0]  d0;
   logic [3:0]  d1;
   logic [3:0]  d2;
   logic        value_ok;

   assign v         = number_in[13:0];
   assign prod_10   = 28'(v) * 28'(RECIP_10);
   assign prod_100  = 28'(v) * 28'(RECIP_100);
   assign prod_1000 = 28'(v) * 28'(RECIP_1000);
   assign q1 = prod_10[SHIFT_10 +: 10];
   assign q2 = prod_100[SHIFT_100 +: 7];
   assign q3 = prod_1000[SHIFT_1000 +: 4];

   // remainders are below ten, so the low nibble is exact
   assign d0 = 4'(v - 14'(q1) * 14'd10);
   assign d1 = 4'(q1 - 10'(q2) * 10'd10);
   assign d2 = 4'(q2 - 7'(q3) * 7'd10);

   assign value_ok = !number_in[15] && (number_in <= VALUE_MAX);

   always_comb begin
      digits.mode      = mode;
      digits.icon_mask = icon_mask;
      digits.mem_ok    = !number_in[15] && (number_in <= MEMORY_MAX);
      digits.mem_units = d0;
      digits.mem_tens  = q1[3:0];
      if (mode == MODE_ERROR) begin
         digits.dig_a = GLYPH_B;
         digits.dig_b = GLYPH_B;
         digits.dig_c = GLYPH_A;
         digits.dig_d = DIGIT_BLANK;
      end else if (!value_ok) begin
         digits.dig_a = DIGIT_BLANK;
         digits.dig_b = GLYPH_B;
         digits.dig_c = GLYPH_B;
         digits.dig_d = GLYPH_A;
      end else begin
         // blank the two upper leading zeros
         digits.dig_a = d0;
         digits.dig_b = d1;
         digits.dig_c = (q3 == 4'd0 && d2 == 4'd0) ? DIGIT_BLANK : d2;
         digits.dig_d = (q3 == 4'd0) ? DIGIT_BLANK : q3;
      end
   end

endmodule

FILE: design/segment_lcd_number_renderer.sv
// ----------------------------------------------------------------------------
// segment_lcd_number_renderer
// Renders display commands into four glass words over a kept LCD shadow.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one command item (mode, number_in, icon_mask); rsp_ch
//   returns one item of four glass words for every command, in order.
//   Two register stages: the command is split into digits and latched,
//   then the shadow is updated and the glass words are latched, and
//   rsp_ch valid comes from the result register; one item is accepted
//   every cycle while rsp_ch keeps taking results.
//   The shadow is updated when an item enters the result register, so
//   back-to-back commands see each other's effect.
//   Reset clears the shadow to all zero and empties both stages.
//   When the receiver stalls, the result holds, the digit stage fills,
//   and req_ch ready drops until the result is taken.
//   Blank mode outputs zeros and keeps the shadow; modes 6 and 7 output
//   the shadow unchanged.
// ----------------------------------------------------------------------------
module segment_lcd_number_renderer (
   input  logic       clock,
   input  logic       reset,
   slcd_req_if.sink   req_ch,
   slcd_rsp_if.source rsp_ch
);
   import slcd_pkg::*;

   digits_type      digits;
   digits_type      s1_ff;
   logic            s1_valid_ff;
   logic            rsp_valid_ff;
   glass_words_type shadow_ff;
   glass_words_type shadow_in;
   glass_words_type rsp_words_ff;
   glass_words_type rsp_words_in;
   glass_words_type packed_words;
   glass_words_type icon_bits;
   logic            out_free;
   logic            s2_take;
   logic            s1_free;

   slcd_digits u_digits (
      .mode      (req_ch.mode),
      .number_in (req_ch.number_in),
      .icon_mask (req_ch.icon_mask),
      .digits    (digits)
   );

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s2_take      = s1_valid_ff && out_free;
   assign s1_free      = !s1_valid_ff || s2_take;
   assign req_ch.ready = s1_free;

   assign packed_words = pack_digits(s1_ff.dig_a, s1_ff.dig_b, s1_ff.dig_c, s1_ff.dig_d);

   // per-word masks of the selected icons
   always_comb begin
      icon_bits = '0;
      for (int i = 0; i < NUM_ICONS; i++) begin
         if (s1_ff.icon_mask[i]) begin
            icon_bits[icon_word(i)] = icon_bits[icon_word(i)] | icon_bit(i);
         end
      end
   end

   always_comb begin
      shadow_in    = shadow_ff;
      rsp_words_in = '0;
      case (s1_ff.mode)
         MODE_VALUE: begin
            shadow_in    = packed_words;
            shadow_in[1] = packed_words[1] | DP_BIT;
         end
         MODE_MEMORY: begin
            if (s1_ff.mem_ok) begin
               shadow_in[0] = (shadow_ff[0] & MEM_W0_KEEP)
                            | {8'h0, seg_code(s1_ff.mem_units), 8'h0};
               shadow_in[1] = (shadow_ff[1] & MEM_W1_KEEP)
                            | {16'h0, seg_code(s1_ff.mem_tens)};
            end
         end
         MODE_ERROR: begin
            shadow_in = packed_words;
         end
         MODE_ICON_ON: begin
            for (int w = 0; w < 4; w++) begin
               shadow_in[w] = shadow_ff[w] | icon_bits[w];
            end
         end
         MODE_ICON_OFF: begin
            for (int w = 0; w < 4; w++) begin
               shadow_in[w] = shadow_ff[w] & ~icon_bits[w];
            end
         end
         default: begin
            shadow_in = shadow_ff;
         end
      endcase
      if (s1_ff.mode != MODE_BLANK) begin
         rsp_words_in = shadow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         shadow_ff    <= '0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= req_ch.valid;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s2_take) begin
            shadow_ff <= shadow_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free && req_ch.valid) begin
         s1_ff <= digits;
      end
      if (s2_take) begin
         rsp_words_ff <= rsp_words_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.glass_word0 = rsp_words_ff[0];
   assign rsp_ch.glass_word1 = rsp_words_ff[1];
   assign rsp_ch.glass_word2 = rsp_words_ff[2];
   assign rsp_ch.glass_word3 = rsp_words_ff[3];

endmodule
